>>> design/t1fsd_pkg.sv
// ----------------------------------------------------------------------------
// t1fsd_pkg
// Shared types and constants for the Type 1 font stream decrypt block.
// ----------------------------------------------------------------------------
`default_nettype none

package t1fsd_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_INIT   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULT_C1    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADD_C2     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_COUNT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEX_MODE   = 3'd4;

   // register reset values
   localparam logic [15:0] KEY_INIT_RESET   = 16'd55665;
   localparam logic [15:0] MULT_C1_RESET    = 16'd52845;
   localparam logic [15:0] ADD_C2_RESET     = 16'd22719;
   localparam logic [7:0]  SKIP_COUNT_RESET = 8'd4;
   localparam logic        HEX_MODE_RESET   = 1'b1;

   // token queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // live configuration seen by front and back
   typedef struct packed {
      logic [15:0] key_init;
      logic [15:0] mult_c1;
      logic [15:0] add_c2;
      logic [7:0]  skip_count;
      logic        hex_mode;
   } t1fsd_cfg_type;

   // one classified transaction: a cipher byte and/or a restart
   typedef struct packed {
      logic [7:0] cipher;
      logic       has_byte;
      logic       restart;
      logic       last;
   } t1fsd_token_type;

endpackage

`default_nettype wire

>>> design/t1fsd_req_if.sv
// ----------------------------------------------------------------------------
// t1fsd_req_if
// Input channel: one raw character per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface t1fsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       restart;
   logic       last_char;

   modport source (output valid, output in_char, output restart, output last_char,
                   input ready);
   modport sink   (input valid, input in_char, input restart, input last_char,
                   output ready);
endinterface

`default_nettype wire

>>> design/t1fsd_rsp_if.sv
// ----------------------------------------------------------------------------
// t1fsd_rsp_if
// Result channel: one decrypted byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface t1fsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       last_out;

   modport source (output valid, output plain_byte, output last_out, input ready);
   modport sink   (input valid, input plain_byte, input last_out, output ready);
endinterface

`default_nettype wire

>>> design/type1_font_stream_decrypt_top.sv
// ----------------------------------------------------------------------------
// type1_font_stream_decrypt_top
// Type 1 eexec/charstring stream decryption with hex or binary input.
//
//   channel   dir  handshake         payload
//   req_chan  in   valid/ready       in_char[7:0], restart, last_char
//   rsp_chan  out  valid/ready       plain_byte[7:0], last_out
//   csr_*     in   csr_wr_en         csr_index[2:0], csr_wr_data[15:0]
//
// One character per cycle sustained while rsp_chan is ready; an accepted
// character passes a queue slot, then the output register, to raise rsp valid.
// The back's key loop (add, 16x16 low multiply, add) closes through key_ff.
// Reset is synchronous; control registers return to their documented defaults.
// A stalled rsp_chan fills the four-entry token queue, then drops req ready.
// ----------------------------------------------------------------------------
`default_nettype none

module type1_font_stream_decrypt_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   t1fsd_req_if.sink                                  req_chan,
   t1fsd_rsp_if.source                                rsp_chan,
   input  wire logic                                  csr_wr_en,
   input  wire logic [t1fsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [t1fsd_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);
   import t1fsd_pkg::*;

   t1fsd_cfg_type   cfg_ff;
   logic            push_valid, push_ready;
   t1fsd_token_type push_token;
   logic            pop_valid, pop_ready;
   t1fsd_token_type pop_token;

   // configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_init   <= KEY_INIT_RESET;
         cfg_ff.mult_c1    <= MULT_C1_RESET;
         cfg_ff.add_c2     <= ADD_C2_RESET;
         cfg_ff.skip_count <= SKIP_COUNT_RESET;
         cfg_ff.hex_mode   <= HEX_MODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_INIT:   cfg_ff.key_init   <= csr_wr_data;
            CSR_MULT_C1:    cfg_ff.mult_c1    <= csr_wr_data;
            CSR_ADD_C2:     cfg_ff.add_c2     <= csr_wr_data;
            CSR_SKIP_COUNT: cfg_ff.skip_count <= csr_wr_data[7:0];
            CSR_HEX_MODE:   cfg_ff.hex_mode   <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   t1fsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_token (push_token)
   );

   t1fsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_token  (pop_token),
      .pop_ready  (pop_ready)
   );

   t1fsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_token (pop_token),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> design/t1fsd_front.sv
// ----------------------------------------------------------------------------
// t1fsd_front
// Accepts raw characters, pairs hex digits, drops line breaks in hex mode and
// pushes cipher-byte / restart tokens into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module t1fsd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire t1fsd_pkg::t1fsd_cfg_type   cfg,
   t1fsd_req_if.sink                       req_chan,
   input  wire logic                       push_ready,
   output      logic                       push_valid,
   output      t1fsd_pkg::t1fsd_token_type push_token
);
   import t1fsd_pkg::*;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_F    = 8'h66;
   localparam logic [7:0] DIGIT_TEN  = 8'd10;

   // hex digit value; anything else counts as zero
   function automatic logic [3:0] digit_value(input logic [7:0] ch);
      logic [7:0] v;
      v = 8'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         v = ch - CH_ZERO;
      end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
         v = ch - CH_UP_A + DIGIT_TEN;
      end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
         v = ch - CH_LO_A + DIGIT_TEN;
      end
      return v[3:0];
   endfunction

   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       pending_ff, pending_in;
   logic       accept;
   logic [3:0] hi_cur;
   logic       pend_cur;
   logic [3:0] digit;
   logic       has_byte;
   logic [7:0] cipher;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign digit          = digit_value(req_chan.in_char);

   // classify the character against the nibble state
   always_comb begin
      hi_cur         = req_chan.restart ? 4'd0 : high_nibble_ff;
      pend_cur       = req_chan.restart ? 1'b0 : pending_ff;
      high_nibble_in = hi_cur;
      pending_in     = pend_cur;
      has_byte       = 1'b0;
      cipher         = req_chan.in_char;
      if (cfg.hex_mode) begin
         if (req_chan.in_char == CH_CR || req_chan.in_char == CH_LF) begin
            has_byte = 1'b0;
         end else if (!pend_cur) begin
            high_nibble_in = digit;
            pending_in     = 1'b1;
         end else begin
            cipher     = {hi_cur, digit};
            pending_in = 1'b0;
            has_byte   = 1'b1;
         end
      end else begin
         has_byte = 1'b1;
      end
   end

   // a restart travels even without a byte so the back reloads the key
   assign push_valid          = accept && (has_byte || req_chan.restart);
   assign push_token.cipher   = cipher;
   assign push_token.has_byte = has_byte;
   assign push_token.restart  = req_chan.restart;
   assign push_token.last     = req_chan.last_char;

   // nibble state
   always_ff @(posedge clock) begin
      if (reset) begin
         high_nibble_ff <= 4'd0;
         pending_ff     <= 1'b0;
      end else if (accept) begin
         high_nibble_ff <= high_nibble_in;
         pending_ff     <= pending_in;
      end
   end

   // a line break in hex mode leaves the nibble state alone
   a_crlf_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && cfg.hex_mode && !req_chan.restart &&
       (req_chan.in_char == CH_CR || req_chan.in_char == CH_LF))
      |=> pending_ff == $past(pending_ff) && high_nibble_ff == $past(high_nibble_ff))
      else $error("line break changed nibble state");

   // a completed pair always clears the pending flag
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && cfg.hex_mode && has_byte) |=> !pending_ff)
      else $error("pending flag left set after pair");

   // nothing is pushed without room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("push without queue room");

endmodule

`default_nettype wire

>>> design/t1fsd_queue.sv
// ----------------------------------------------------------------------------
// t1fsd_queue
// Small token queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module t1fsd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire t1fsd_pkg::t1fsd_token_type push_token,
   output      logic                       push_ready,
   output      logic                       pop_valid,
   output      t1fsd_pkg::t1fsd_token_type pop_token,
   input  wire logic                       pop_ready
);
   import t1fsd_pkg::*;

   localparam logic [QUEUE_CNT_W-1:0] DEPTH_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR  = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   t1fsd_token_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                        push, pop;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count out of range");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

>>> design/t1fsd_back.sv
// ----------------------------------------------------------------------------
// t1fsd_back
// Applies restarts, decrypts cipher bytes, updates the key, drops leading
// bytes and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module t1fsd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire t1fsd_pkg::t1fsd_cfg_type   cfg,
   input  wire logic                       pop_valid,
   input  wire t1fsd_pkg::t1fsd_token_type pop_token,
   output      logic                       pop_ready,
   t1fsd_rsp_if.source                     rsp_chan
);
   import t1fsd_pkg::*;

   logic [15:0] key_ff, key_in;
   logic [7:0]  discard_ff, discard_in;
   logic        out_valid_ff;
   logic [7:0]  out_plain_ff;
   logic        out_last_ff;
   logic [15:0] key_cur;
   logic [7:0]  disc_cur;
   logic [15:0] sum;
   logic [15:0] key_next;
   logic [7:0]  plain;
   logic        produce;
   logic        pop;

   // restart takes effect before this byte
   assign key_cur  = pop_token.restart ? cfg.key_init : key_ff;
   assign disc_cur = pop_token.restart ? cfg.skip_count : discard_ff;

   // decrypt and key update: key = (c + key) * c1 + c2 mod 2^16
   assign plain    = pop_token.cipher ^ key_cur[15:8];
   assign sum      = {8'd0, pop_token.cipher} + key_cur;
   assign key_next = sum * cfg.mult_c1 + cfg.add_c2;

   assign produce  = pop_token.has_byte && (disc_cur == 8'd0);

   always_comb begin
      key_in     = key_cur;
      discard_in = disc_cur;
      if (pop_token.has_byte) begin
         key_in = key_next;
         if (disc_cur != 8'd0) begin
            discard_in = disc_cur - 8'd1;
         end
      end
   end

   // tokens without a result never wait on the output register
   assign pop_ready = !produce || !out_valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= KEY_INIT_RESET;
         discard_ff <= SKIP_COUNT_RESET;
      end else if (pop) begin
         key_ff     <= key_in;
         discard_ff <= discard_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produce) begin
         out_plain_ff <= plain;
         out_last_ff  <= pop_token.last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.plain_byte = out_plain_ff;
   assign rsp_chan.last_out   = out_last_ff;

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (pop && produce) |=> out_valid_ff && out_plain_ff == $past(plain))
      else $error("result not loaded into output register");

   a_discard_step: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_token.has_byte && disc_cur != 8'd0)
      |=> discard_ff == $past(disc_cur) - 8'd1 && !$rose(out_valid_ff))
      else $error("dropped byte handled wrong");

   a_restart_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !pop_token.has_byte) |=> key_ff == $past(key_cur))
      else $error("key changed without a byte");

endmodule

`default_nettype wire
